### rtl/dwepc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwepc_pkg: shared types and constants for the wheel pulse counter
// Payload structs, register codes, window sizing and the per-wheel qualifier.
// ----------------------------------------------------------------------------
package dwepc_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int LOCKOUT_W  = 16;
  localparam int CFG_DATA_W = 16;

  // averaging window depth, 1 to 16
  localparam int WIN_LEN = 3;
  localparam int POS_W   = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int SUM_W   = $clog2(WIN_LEN * (2**SAMPLE_W - 1) + 1);

  // divide by WIN_LEN as multiply by a rounded-up reciprocal; the error term
  // stays below 1/WIN_LEN over the whole sum range, so the floor is exact
  localparam int RECIP_SH = SUM_W + $clog2(WIN_LEN) + 1;
  localparam int RECIP    = (2**RECIP_SH + WIN_LEN - 1) / WIN_LEN;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int PROD_W   = SUM_W + RECIP_W;

  localparam logic [SAMPLE_W-1:0]  LOW_THR_RST  = SAMPLE_W'(500);
  localparam logic [SAMPLE_W-1:0]  HIGH_THR_RST = SAMPLE_W'(600);
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST  = LOCKOUT_W'(300);

  typedef enum logic [1:0] {
    CFG_LOW_THR  = 2'd0,
    CFG_HIGH_THR = 2'd1,
    CFG_LOCKOUT  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left_sample;
    logic [SAMPLE_W-1:0] right_sample;
    logic [TIME_W-1:0]   now_us;
    logic                clear_counts;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] left_count;
    logic [COUNT_W-1:0] right_count;
    logic               left_level;
    logic               right_level;
  } out_item_t;

  typedef struct packed {
    logic               level;
    logic [TIME_W-1:0]  fall_time;
    logic [TIME_W-1:0]  rise_time;
    logic [COUNT_W-1:0] count;
  } wheel_t;

  localparam wheel_t WHEEL_RST = '{level: 1'b1, fall_time: '0, rise_time: '0, count: '0};

  function automatic logic [SAMPLE_W-1:0] win_avg(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = {{RECIP_W{1'b0}}, sum} * PROD_W'(RECIP);
    return prod[RECIP_SH +: SAMPLE_W];
  endfunction

  // hysteresis comparator with lockout; low test wins on crossed thresholds
  function automatic wheel_t wheel_step(
    input wheel_t                cur,
    input logic [SAMPLE_W-1:0]  avg,
    input logic [TIME_W-1:0]    now,
    input logic [SAMPLE_W-1:0]  low_thr,
    input logic [SAMPLE_W-1:0]  high_thr,
    input logic [LOCKOUT_W-1:0] lockout,
    input logic                 clr
  );
    wheel_t            nxt;
    logic [TIME_W-1:0] since_rise;
    logic [TIME_W-1:0] since_fall;
    nxt        = cur;
    since_rise = now - cur.rise_time;
    since_fall = now - cur.fall_time;
    if (clr) begin
      nxt.count = '0;
    end
    if (avg < low_thr) begin
      if (cur.level && (since_rise > TIME_W'(lockout))) begin
        nxt.level     = 1'b0;
        nxt.fall_time = now;
        nxt.count     = nxt.count + COUNT_W'(1);
      end
    end else if (avg > high_thr) begin
      if (!cur.level && (since_fall > TIME_W'(lockout))) begin
        nxt.level     = 1'b1;
        nxt.rise_time = now;
      end
    end
    return nxt;
  endfunction

endpackage

### rtl/dual_wheel_encoder_pulse_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_encoder_pulse_counter_core: two-wheel encoder pulse counter
// Averages each wheel's recent samples, qualifies them through a hysteresis
// comparator with lockout and counts falling transitions per wheel.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_stall    | in_data  (samples, timestamp, clear)
//  out     | out_valid / out_stall  | out_data (counts, levels)
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
//  one item per cycle sustained while out_stall stays low; a result passes
//  through the input register, then the result register
//  the window add, reciprocal multiply and 32-bit elapsed-time compare sit
//  between the two registers
//  rst is synchronous: thresholds go to 500/600, lockout to 300, windows
//  and times to zero, levels high, counters zero
//  a stalled result holds; in_stall rises only while the input register is
//  full and the result register cannot drain
// ----------------------------------------------------------------------------
module dual_wheel_encoder_pulse_counter_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  dwepc_pkg::in_item_t                    in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output dwepc_pkg::out_item_t                   out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  dwepc_pkg::cfg_reg_t                    cfg_index,
  input  logic [dwepc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import dwepc_pkg::*;

  logic [SAMPLE_W-1:0]  low_thr;
  logic [SAMPLE_W-1:0]  high_thr;
  logic [LOCKOUT_W-1:0] lockout;

  logic                 s1_vld;
  in_item_t             s1_data;
  logic                 adv;
  logic                 in_xfer;

  logic [SAMPLE_W-1:0]  left_win  [WIN_LEN];
  logic [SAMPLE_W-1:0]  right_win [WIN_LEN];
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     pos_next;
  wheel_t               left_whl;
  wheel_t               right_whl;
  wheel_t               left_whl_next;
  wheel_t               right_whl_next;
  logic [SUM_W-1:0]     left_sum;
  logic [SUM_W-1:0]     right_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr  <= LOW_THR_RST;
      high_thr <= HIGH_THR_RST;
      lockout  <= LOCKOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOW_THR:  low_thr  <= cfg_data[SAMPLE_W-1:0];
        CFG_HIGH_THR: high_thr <= cfg_data[SAMPLE_W-1:0];
        CFG_LOCKOUT:  lockout  <= cfg_data[LOCKOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register drains whenever the result register is empty or taken
  assign adv      = s1_vld && (!out_valid || !out_stall);
  assign in_stall = s1_vld && !adv;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (in_xfer) begin
      s1_vld <= 1'b1;
    end else if (adv) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data <= in_data;
    end
  end

  // window sums with the new sample replacing the oldest entry
  always_comb begin
    left_sum  = '0;
    right_sum = '0;
    for (int i = 0; i < WIN_LEN; i++) begin
      if (pos == POS_W'(i)) begin
        left_sum  = left_sum + SUM_W'(s1_data.left_sample);
        right_sum = right_sum + SUM_W'(s1_data.right_sample);
      end else begin
        left_sum  = left_sum + SUM_W'(left_win[i]);
        right_sum = right_sum + SUM_W'(right_win[i]);
      end
    end
  end

  assign pos_next = (pos == POS_W'(WIN_LEN - 1)) ? '0 : pos + POS_W'(1);

  assign left_whl_next = wheel_step(left_whl, win_avg(left_sum), s1_data.now_us,
                                    low_thr, high_thr, lockout, s1_data.clear_counts);
  assign right_whl_next = wheel_step(right_whl, win_avg(right_sum), s1_data.now_us,
                                     low_thr, high_thr, lockout, s1_data.clear_counts);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      left_whl  <= WHEEL_RST;
      right_whl <= WHEEL_RST;
      for (int i = 0; i < WIN_LEN; i++) begin
        left_win[i]  <= '0;
        right_win[i] <= '0;
      end
    end else if (adv) begin
      pos            <= pos_next;
      left_whl       <= left_whl_next;
      right_whl      <= right_whl_next;
      left_win[pos]  <= s1_data.left_sample;
      right_win[pos] <= s1_data.right_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.left_count  <= left_whl_next.count;
      out_data.right_count <= right_whl_next.count;
      out_data.left_level  <= left_whl_next.level;
      out_data.right_level <= right_whl_next.level;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(WIN_LEN - 1))
    else $error("window position out of range");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_vld && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(left_whl.level) && $stable(right_whl.level)))
    else $error("level changed without an item");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (adv && !s1_data.clear_counts) |=>
      (left_whl.count == $past(left_whl.count) ||
       left_whl.count == $past(left_whl.count) + COUNT_W'(1)))
    else $error("left count moved by more than one");

  a_result_matches: assert property (@(posedge clk) disable iff (rst)
    adv |=> (out_valid && out_data.left_count == left_whl.count &&
             out_data.right_level == right_whl.level))
    else $error("result register out of step with wheel state");

endmodule
